/* hw/rtl/sbsub_pkg.sv */
// Shared widths, limb constants and the controller-to-datapath command bundle
// for the signed base-1e9 subtract unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbsub_pkg;

  localparam int unsigned LIMB_W        = 30;
  localparam int unsigned LIMBS_DEFAULT = 8;

  localparam logic [LIMB_W-1:0] LIMB_MAX  = 30'd999999999;
  localparam logic [LIMB_W:0]   LIMB_BASE = 31'd1000000000;

  typedef struct packed {
    logic load;      // a pair transfer on the input channel
    logic clear;     // operation done, empty the stores
    logic rd_en;     // read both stores at the current index
    logic cmp_init;  // start the magnitude compare
    logic cmp_en;    // fold the limbs just read into the compare
    logic op_init;   // start the add or subtract pass
    logic op_en;     // compute one result limb into the output register
    logic op_last;   // the limb being computed is the top one
  } cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/sbsub_if.sv */
// Valid/ready channel interfaces for limb pairs in and result limbs out.
// Depends on sbsub_pkg for the limb width.
`timescale 1ns / 1ps
`default_nettype none

interface sbsub_pair_if;
  logic                            valid;
  logic                            ready;
  logic [sbsub_pkg::LIMB_W-1:0]    a_limb;
  logic [sbsub_pkg::LIMB_W-1:0]    b_limb;
  logic                            a_negative;
  logic                            b_negative;
  logic                            final_pair;

  modport source (output valid, a_limb, b_limb, a_negative, b_negative, final_pair,
                  input ready);
  modport sink   (input valid, a_limb, b_limb, a_negative, b_negative, final_pair,
                  output ready);
endinterface

interface sbsub_res_if;
  logic                            valid;
  logic                            ready;
  logic [sbsub_pkg::LIMB_W-1:0]    result_limb;
  logic                            result_negative;
  logic                            overflow;
  logic                            last_limb;

  modport source (output valid, result_limb, result_negative, overflow, last_limb,
                  input ready);
  modport sink   (input valid, result_limb, result_negative, overflow, last_limb,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/sbsub_ctrl.sv */
// Sequencer for the subtract unit: load, compare walk, limb pass, output.
// Depends on sbsub_pkg for the command bundle.
`timescale 1ns / 1ps
`default_nettype none

module sbsub_ctrl #(
  parameter int unsigned LIMBS = sbsub_pkg::LIMBS_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic                       in_final_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output sbsub_pkg::cmd_t                 cmd_o,
  output logic [$clog2(LIMBS)-1:0]        rd_addr_o
);

  localparam int unsigned AW = $clog2(LIMBS);
  localparam logic [AW-1:0] TOP_IDX = AW'(LIMBS - 1);

  localparam logic [2:0] S_LOAD   = 3'd0;
  localparam logic [2:0] S_CMP_RD = 3'd1;
  localparam logic [2:0] S_CMP_EV = 3'd2;
  localparam logic [2:0] S_OP_RD  = 3'd3;
  localparam logic [2:0] S_OP_EV  = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0]    state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_final_i) begin
            cmd_o.cmp_init = 1'b1;
            idx_d          = TOP_IDX;
            state_d        = S_CMP_RD;
          end
        end
      end
      S_CMP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CMP_EV;
      end
      S_CMP_EV: begin
        cmd_o.cmp_en = 1'b1;
        if (idx_q == '0) begin
          cmd_o.op_init = 1'b1;
          state_d       = S_OP_RD;
        end else begin
          idx_d   = idx_q - 1'b1;
          state_d = S_CMP_RD;
        end
      end
      S_OP_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_OP_EV;
      end
      S_OP_EV: begin
        cmd_o.op_en   = 1'b1;
        cmd_o.op_last = (idx_q == TOP_IDX);
        state_d       = S_OUT;
      end
      S_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          if (idx_q == TOP_IDX) begin
            cmd_o.clear = 1'b1;
            idx_d       = '0;
            state_d     = S_LOAD;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_OP_RD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
        idx_d   = '0;
      end
    endcase
  end

  assign rd_addr_o = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sbsub_dp.sv */
// Datapath: limb stores with fill count, magnitude compare, add/subtract
// limb unit and output register. Depends on sbsub_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sbsub_dp #(
  parameter int unsigned LIMBS = sbsub_pkg::LIMBS_DEFAULT
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire sbsub_pkg::cmd_t              cmd_i,
  input  wire logic [$clog2(LIMBS)-1:0]     rd_addr_i,
  input  wire logic [sbsub_pkg::LIMB_W-1:0] a_limb_i,
  input  wire logic [sbsub_pkg::LIMB_W-1:0] b_limb_i,
  input  wire logic                         a_negative_i,
  input  wire logic                         b_negative_i,
  output logic [sbsub_pkg::LIMB_W-1:0]      result_limb_o,
  output logic                              result_negative_o,
  output logic                              overflow_o,
  output logic                              last_limb_o
);

  localparam int unsigned LW = sbsub_pkg::LIMB_W;
  localparam int unsigned AW = $clog2(LIMBS);
  localparam int unsigned CW = $clog2(LIMBS + 1);

  logic [LW-1:0] mem_a [LIMBS];
  logic [LW-1:0] mem_b [LIMBS];

  logic [CW-1:0] fill_q;
  logic          room;
  logic [LW-1:0] a_clamp, b_clamp;

  logic [LW-1:0] rd_a_q, rd_b_q;
  logic          rd_hit_q;
  logic [LW-1:0] a_val, b_val;

  logic a_neg_q, b_neg_q;
  logic eq_q, gt_q, a_zero_q;
  logic cb_q;

  logic          adding, swap, neg_raw, res_zero;
  logic [LW-1:0] big, small_v;
  logic [LW:0]   need, sum;
  logic [LW-1:0] limb_d;
  logic          cb_d;

  assign room    = (fill_q < CW'(LIMBS));
  assign a_clamp = (a_limb_i > sbsub_pkg::LIMB_MAX) ? sbsub_pkg::LIMB_MAX : a_limb_i;
  assign b_clamp = (b_limb_i > sbsub_pkg::LIMB_MAX) ? sbsub_pkg::LIMB_MAX : b_limb_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) begin
      mem_a[fill_q[AW-1:0]] <= a_clamp;
      mem_b[fill_q[AW-1:0]] <= b_clamp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_a_q   <= mem_a[rd_addr_i];
      rd_b_q   <= mem_b[rd_addr_i];
      rd_hit_q <= (CW'(rd_addr_i) < fill_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else if (cmd_i.clear) begin
      fill_q <= '0;
    end else if (cmd_i.load && room) begin
      fill_q <= fill_q + 1'b1;
    end
  end

  assign a_val = rd_hit_q ? rd_a_q : '0;
  assign b_val = rd_hit_q ? rd_b_q : '0;

  assign adding   = a_neg_q ^ b_neg_q;
  assign swap     = !adding && !eq_q && !gt_q;
  assign big      = swap ? b_val : a_val;
  assign small_v  = swap ? a_val : b_val;
  assign neg_raw  = adding ? a_neg_q : (swap ? !a_neg_q : a_neg_q);
  assign res_zero = eq_q && (!adding || a_zero_q);

  always_comb begin
    need   = {1'b0, small_v} + {{LW{1'b0}}, cb_q};
    sum    = {1'b0, a_val} + {1'b0, b_val} + {{LW{1'b0}}, cb_q};
    limb_d = '0;
    cb_d   = 1'b0;
    if (adding) begin
      if (sum >= sbsub_pkg::LIMB_BASE) begin
        limb_d = LW'(sum - sbsub_pkg::LIMB_BASE);
        cb_d   = 1'b1;
      end else begin
        limb_d = sum[LW-1:0];
      end
    end else begin
      if ({1'b0, big} < need) begin
        limb_d = LW'({1'b0, big} + sbsub_pkg::LIMB_BASE - need);
        cb_d   = 1'b1;
      end else begin
        limb_d = LW'({1'b0, big} - need);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_neg_q <= a_negative_i;
      b_neg_q <= b_negative_i;
    end
    if (cmd_i.cmp_init) begin
      eq_q     <= 1'b1;
      gt_q     <= 1'b0;
      a_zero_q <= 1'b1;
    end else if (cmd_i.cmp_en) begin
      if (eq_q && (a_val != b_val)) begin
        eq_q <= 1'b0;
        gt_q <= (a_val > b_val);
      end
      a_zero_q <= a_zero_q && (a_val == '0);
    end
    if (cmd_i.op_init) begin
      cb_q <= 1'b0;
    end else if (cmd_i.op_en) begin
      cb_q <= cb_d;
    end
    if (cmd_i.op_en) begin
      result_limb_o     <= limb_d;
      result_negative_o <= neg_raw && !res_zero;
      overflow_o        <= cmd_i.op_last && adding && cb_d;
      last_limb_o       <= cmd_i.op_last;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/signed_bignum_base1e9_subtract_unit.sv */
// Top level of the signed base-1e9 subtract unit: computes A - B on
// signed-magnitude operands of LIMBS limbs. Uses sbsub_pkg, sbsub_if,
// sbsub_ctrl and sbsub_dp.
//
// Usage:
//   pair_i carries one limb pair per transfer, least significant first, with
//   the two sign flags; the transfer with final_pair set starts the operation
//   and its signs are the ones used. Pairs beyond LIMBS are dropped, missing
//   limbs count as zero, limbs above 999999999 are clamped on load.
//   res_o then delivers exactly LIMBS result limbs, least significant first,
//   each with the result sign; last_limb is set on the top one, overflow only there.
// Sequence:
//   Pairs load at one per cycle, then the compare walks the limbs from the top
//   limb down, then each result limb takes a store read, a limb compute and an
//   output transfer; the store read port paces both walks. pair_i.ready is low
//   from the final transfer until the last result is taken. A stalled result
//   holds in the output register until res_o.ready.
// Reset:
//   Clears the sequencer and the fill count; the stores read as zero.
`timescale 1ns / 1ps
`default_nettype none

module signed_bignum_base1e9_subtract_unit #(
  parameter int unsigned LIMBS = sbsub_pkg::LIMBS_DEFAULT
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sbsub_pair_if.sink  pair_i,
  sbsub_res_if.source res_o
);

  sbsub_pkg::cmd_t            cmd;
  logic [$clog2(LIMBS)-1:0]   rd_addr;

  sbsub_ctrl #(
    .LIMBS (LIMBS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pair_i.valid),
    .in_final_i  (pair_i.final_pair),
    .in_ready_o  (pair_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr)
  );

  sbsub_dp #(
    .LIMBS (LIMBS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .rd_addr_i         (rd_addr),
    .a_limb_i          (pair_i.a_limb),
    .b_limb_i          (pair_i.b_limb),
    .a_negative_i      (pair_i.a_negative),
    .b_negative_i      (pair_i.b_negative),
    .result_limb_o     (res_o.result_limb),
    .result_negative_o (res_o.result_negative),
    .overflow_o        (res_o.overflow),
    .last_limb_o       (res_o.last_limb)
  );

endmodule

`default_nettype wire

/* tb/signed_bignum_base1e9_subtract_unit_test.sv */
// Self-checking testbench for signed_bignum_base1e9_subtract_unit: drives limb pairs,
// predicts every result limb and checks them in order. Needs sbsub_pkg, sbsub_if
// and the unit's RTL.
`timescale 1ns / 1ps

module signed_bignum_base1e9_subtract_unit_test;

  localparam int unsigned LIMBS          = sbsub_pkg::LIMBS_DEFAULT;
  localparam int unsigned LIMB_W         = sbsub_pkg::LIMB_W;
  localparam int unsigned DIRECTED_N     = 25;
  localparam int unsigned RANDOM_ITEMS   = 95;
  localparam int unsigned CALM_FROM      = 75;
  localparam int unsigned WATCHDOG_LIMIT = 500;

  typedef logic [LIMB_W-1:0] limb_t;

  localparam limb_t             LIMB_MAX  = sbsub_pkg::LIMB_MAX;
  localparam logic [LIMB_W:0]   LIMB_BASE = sbsub_pkg::LIMB_BASE;
  localparam limb_t             TOP_LIMB  = 30'h3FFF_FFFF;

  typedef enum int unsigned {MIXED, MIRROR, HEAVY, SPARSE} shape_e;

  typedef struct packed {
    limb_t a;
    limb_t b;
    logic  an;
    logic  bn;
    logic  fin;
  } pair_t;

  typedef struct packed {
    limb_t limb;
    logic  neg;
    logic  ovf;
    logic  last;
  } res_t;

  typedef struct packed {
    pair_t item;
    logic  typed;
    limb_t t_lo;
    limb_t t_rest;
    logic  t_neg;
    logic  t_ovf;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    //   a          b         an bn fin  typed lo            rest      neg ovf
    '{'{30'd0,    30'd0,    0, 0, 1}, 1, 30'd0,        30'd0,    0, 0},
    '{'{30'd5,    30'd7,    0, 0, 1}, 1, 30'd2,        30'd0,    1, 0},
    '{'{30'd5,    30'd5,    1, 1, 1}, 1, 30'd0,        30'd0,    0, 0},
    '{'{TOP_LIMB, 30'd0,    0, 0, 1}, 1, LIMB_MAX,     30'd0,    0, 0},
    '{'{30'd0,    TOP_LIMB, 1, 0, 1}, 1, LIMB_MAX,     30'd0,    1, 0},
    '{'{LIMB_MAX, LIMB_MAX, 1, 1, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{LIMB_MAX, LIMB_MAX, 1, 0, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{LIMB_MAX, LIMB_MAX, 0, 0, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{LIMB_MAX, LIMB_MAX, 0, 1, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{LIMB_MAX, LIMB_MAX, 1, 1, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{LIMB_MAX, LIMB_MAX, 0, 0, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{LIMB_MAX, LIMB_MAX, 1, 0, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{LIMB_MAX, LIMB_MAX, 0, 1, 1}, 1, LIMB_MAX - 1, LIMB_MAX, 0, 1},
    '{'{TOP_LIMB, LIMB_MAX, 0, 0, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{TOP_LIMB, LIMB_MAX, 1, 1, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{TOP_LIMB, LIMB_MAX, 0, 1, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{TOP_LIMB, LIMB_MAX, 1, 0, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{TOP_LIMB, LIMB_MAX, 0, 0, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{TOP_LIMB, LIMB_MAX, 1, 1, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{TOP_LIMB, LIMB_MAX, 0, 1, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{TOP_LIMB, LIMB_MAX, 1, 0, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{30'd12345, TOP_LIMB, 1, 0, 1}, 1, LIMB_MAX - 1, LIMB_MAX, 1, 1},
    '{'{30'd0,    30'd1,    0, 1, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{30'd0,    30'd0,    1, 0, 0}, 0, 30'd0,        30'd0,    0, 0},
    '{'{30'd1,    30'd0,    1, 1, 1}, 0, 30'd0,        30'd0,    0, 0}
  };

  logic clk_i;
  logic rst_ni;

  sbsub_pair_if pair_ch ();
  sbsub_res_if  res_ch ();

  signed_bignum_base1e9_subtract_unit #(.LIMBS(LIMBS)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pair_i (pair_ch),
    .res_o  (res_ch)
  );

  limb_t       minuend_mag    [LIMBS];
  limb_t       subtrahend_mag [LIMBS];
  int unsigned pairs_held;
  res_t        fresh_limbs    [$];
  res_t        pending_limbs  [$];
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned random_items   = 0;
  bit          calm_phase     = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic limb_t saturate(limb_t v);
    return (v > LIMB_MAX) ? LIMB_MAX : v;
  endfunction

  function automatic void clear_stores();
    for (int i = 0; i < LIMBS; i++) begin
      minuend_mag[i]    = '0;
      subtrahend_mag[i] = '0;
    end
    pairs_held = 0;
  endfunction

  // Load one pair; on the final pair compute the signed difference into fresh_limbs.
  function automatic void fold_pair_into_difference(pair_t p);
    limb_t       big    [LIMBS];
    limb_t       little [LIMBS];
    limb_t       diff   [LIMBS];
    logic [31:0] acc;
    logic        carry;
    logic        ovf;
    logic        neg;
    logic        a_larger;
    logic        all_zero;
    fresh_limbs.delete();
    if (pairs_held < LIMBS) begin
      minuend_mag[pairs_held]    = saturate(p.a);
      subtrahend_mag[pairs_held] = saturate(p.b);
      pairs_held++;
    end
    if (!p.fin) return;
    carry = 1'b0;
    ovf   = 1'b0;
    if (p.an == p.bn) begin
      a_larger = 1'b1;
      for (int i = LIMBS - 1; i >= 0; i--) begin
        if (minuend_mag[i] != subtrahend_mag[i]) begin
          a_larger = minuend_mag[i] > subtrahend_mag[i];
          break;
        end
      end
      for (int i = 0; i < LIMBS; i++) begin
        big[i]    = a_larger ? minuend_mag[i] : subtrahend_mag[i];
        little[i] = a_larger ? subtrahend_mag[i] : minuend_mag[i];
      end
      neg = a_larger ? p.an : !p.an;
      for (int i = 0; i < LIMBS; i++) begin
        acc = 32'(little[i]) + 32'(carry);
        if (32'(big[i]) < acc) begin
          diff[i] = limb_t'(32'(big[i]) + 32'(LIMB_BASE) - acc);
          carry   = 1'b1;
        end else begin
          diff[i] = limb_t'(32'(big[i]) - acc);
          carry   = 1'b0;
        end
      end
    end else begin
      for (int i = 0; i < LIMBS; i++) begin
        acc = 32'(minuend_mag[i]) + 32'(subtrahend_mag[i]) + 32'(carry);
        if (acc >= 32'(LIMB_BASE)) begin
          diff[i] = limb_t'(acc - 32'(LIMB_BASE));
          carry   = 1'b1;
        end else begin
          diff[i] = limb_t'(acc);
          carry   = 1'b0;
        end
      end
      ovf = carry;
      neg = p.an;
    end
    all_zero = 1'b1;
    for (int i = 0; i < LIMBS; i++) begin
      if (diff[i] != '0) all_zero = 1'b0;
    end
    if (all_zero && !ovf) neg = 1'b0;
    for (int i = 0; i < LIMBS; i++) begin
      fresh_limbs.push_back('{diff[i], neg, (i == LIMBS - 1) ? ovf : 1'b0, i == LIMBS - 1});
    end
    clear_stores();
  endfunction

  function automatic limb_t pick_limb(shape_e style);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (style == HEAVY && roll < 7) begin
      return (roll < 5) ? LIMB_MAX : limb_t'($urandom_range(32'(LIMB_MAX) + 1, TOP_LIMB));
    end
    if (style == SPARSE && roll < 7) return limb_t'($urandom_range(0, 2));
    case (roll)
      0: return '0;
      1: return LIMB_MAX;
      2: return limb_t'($urandom_range(32'(LIMB_MAX) + 1, TOP_LIMB));
      3: return limb_t'($urandom_range(0, 3));
      default: return limb_t'($urandom_range(0, LIMB_MAX));
    endcase
  endfunction

  task automatic transfer_pair(pair_t p);
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      pair_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    pair_ch.a_limb     <= p.a;
    pair_ch.b_limb     <= p.b;
    pair_ch.a_negative <= p.an;
    pair_ch.b_negative <= p.bn;
    pair_ch.final_pair <= p.fin;
    pair_ch.valid      <= 1'b1;
    @(posedge clk_i);
    while (!pair_ch.ready) @(posedge clk_i);
    fold_pair_into_difference(p);
  endtask

  task automatic run_random_op();
    int unsigned npairs;
    shape_e      style;
    pair_t       p;
    npairs = ($urandom_range(0, 7) == 0) ? $urandom_range(LIMBS + 1, LIMBS + 3)
                                         : $urandom_range(1, LIMBS);
    style  = shape_e'($urandom_range(0, 3));
    for (int k = 0; k < npairs; k++) begin
      p.a = pick_limb((style == MIRROR) ? MIXED : style);
      if (style == MIRROR) begin
        p.b = ($urandom_range(0, 5) == 0) ? pick_limb(MIXED) : p.a;
      end else begin
        p.b = pick_limb(style);
      end
      p.an  = 1'($urandom_range(0, 1));
      p.bn  = 1'($urandom_range(0, 1));
      p.fin = (k == npairs - 1);
      transfer_pair(p);
      random_items++;
      if (random_items >= CALM_FROM) calm_phase = 1'b1;
    end
    foreach (fresh_limbs[i]) pending_limbs.push_back(fresh_limbs[i]);
  endtask

  initial begin : stimulus
    stim_row_t row;
    rst_ni             <= 1'b0;
    pair_ch.valid      <= 1'b0;
    pair_ch.a_limb     <= '0;
    pair_ch.b_limb     <= '0;
    pair_ch.a_negative <= 1'b0;
    pair_ch.b_negative <= 1'b0;
    pair_ch.final_pair <= 1'b0;
    clear_stores();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIRECTED_N; r++) begin
      row = DIRECTED_ROWS[r];
      transfer_pair(row.item);
      if (row.item.fin) begin
        if (row.typed) begin
          for (int i = 0; i < LIMBS; i++) begin
            pending_limbs.push_back('{(i == 0) ? row.t_lo : row.t_rest, row.t_neg,
                                      (i == LIMBS - 1) ? row.t_ovf : 1'b0, i == LIMBS - 1});
          end
        end else begin
          foreach (fresh_limbs[i]) pending_limbs.push_back(fresh_limbs[i]);
        end
      end
    end

    // hold off until the unit has drained
    pair_ch.valid <= 1'b0;
    while (pending_limbs.size() != 0) @(posedge clk_i);

    while (random_items < RANDOM_ITEMS) run_random_op();
    pair_ch.valid <= 1'b0;

    while (pending_limbs.size() != 0) @(posedge clk_i);
    repeat (5 * LIMBS) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin : result_pacing
    res_ch.ready <= 1'b0;
    @(posedge clk_i);
    while (rst_ni !== 1'b1) @(posedge clk_i);
    forever begin
      res_ch.ready <= 1'b1;
      if (calm_phase) begin
        @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
        if ($urandom_range(0, 2) == 0) begin
          res_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 17)) @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    res_t seen;
    res_t want;
    if (res_ch.valid && res_ch.ready) begin
      seen = '{res_ch.result_limb, res_ch.result_negative, res_ch.overflow, res_ch.last_limb};
      if (pending_limbs.size() == 0) begin
        mismatch_count++;
        if (mismatch_count < 50) begin
          $display("%0t: unexpected result transfer, expected none, actual limb %0d neg %b ovf %b last %b",
                   $time, seen.limb, seen.neg, seen.ovf, seen.last);
        end
      end else begin
        want = pending_limbs.pop_front();
        if (seen.limb !== want.limb || seen.neg !== want.neg ||
            seen.ovf !== want.ovf || seen.last !== want.last) begin
          mismatch_count++;
          if (mismatch_count < 50) begin
            $display("%0t: expected limb %0d neg %b ovf %b last %b, actual limb %0d neg %b ovf %b last %b",
                     $time, want.limb, want.neg, want.ovf, want.last,
                     seen.limb, seen.neg, seen.ovf, seen.last);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((pair_ch.valid && pair_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, pending_limbs.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
